@@ sv/ccdp_pkg.sv @@
// Shared types, constants and keyword table for the Cache-Control directive parser.
package ccdp_pkg;

  localparam int AGE_BITS = 32;
  localparam int OUT_AGE_W = 32;
  localparam int PROD_W = AGE_BITS + 4;

  // Directive phase codes
  localparam logic [2:0] PH_LEAD       = 3'd0;
  localparam logic [2:0] PH_NAME       = 3'd1;
  localparam logic [2:0] PH_VAL_WS     = 3'd2;
  localparam logic [2:0] PH_VAL_SIGN   = 3'd3;
  localparam logic [2:0] PH_VAL_DIGITS = 3'd4;
  localparam logic [2:0] PH_VAL_DONE   = 3'd5;
  localparam logic [2:0] PH_DEAD       = 3'd6;

  localparam int NUM_KW = 5;
  localparam int KW_NOSTORE = 0;
  localparam int KW_NOCACHE = 1;
  localparam int KW_PRIVATE = 2;
  localparam int KW_MAXAGE  = 3;
  localparam int KW_SMAXAGE = 4;

  localparam logic [NUM_KW-1:0] KW_ALL      = '1;
  localparam logic [NUM_KW-1:0] KW_ONLY_MAX = NUM_KW'(1) << KW_MAXAGE;
  localparam logic [NUM_KW-1:0] KW_ONLY_SMX = NUM_KW'(1) << KW_SMAXAGE;

  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    "no-store", "no-cache", {"private", 8'h00}, {"max-age", 8'h00}, "s-maxage"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd8, 4'd8, 4'd7, 4'd7, 4'd8};

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One request handed from the input register to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
    logic       byte_present;
    logic       is_last;
  } ccdp_step_t;

  typedef struct packed {
    logic                 no_store;
    logic                 no_cache;
    logic                 is_private;
    logic [OUT_AGE_W-1:0] max_age;
    logic                 max_age_present;
    logic [OUT_AGE_W-1:0] shared_max_age;
    logic                 shared_max_age_present;
  } ccdp_policy_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
    logic [63:0] txt;
    txt = KW_TEXT[k];
    return txt[63 - 8*idx -: 8];
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ sv/ccdp_if.sv @@
// Request and result channel interfaces of the Cache-Control directive parser.
interface ccdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, char_byte, byte_present, is_last, input ready);
  modport sink   (input valid, char_byte, byte_present, is_last, output ready);
endinterface

interface ccdp_out_if;
  logic        valid;
  logic        ready;
  logic        no_store;
  logic        no_cache;
  logic        is_private;
  logic [31:0] max_age;
  logic        max_age_present;
  logic [31:0] shared_max_age;
  logic        shared_max_age_present;

  modport source (output valid, no_store, no_cache, is_private, max_age, max_age_present,
                  shared_max_age, shared_max_age_present, input ready);
  modport sink   (input valid, no_store, no_cache, is_private, max_age, max_age_present,
                  shared_max_age, shared_max_age_present, output ready);
endinterface

@@ sv/ccdp_in_reg.sv @@
// Input register: captures one request and releases it to the parser.
module ccdp_in_reg import ccdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ccdp_in_if.sink    in_ch,
  input  logic       out_free,
  output ccdp_step_t step
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic       present_r;
  logic       last_r;
  logic       adv;
  logic       take;

  // A last byte may only move on when the result register can take it
  assign adv         = valid_r && (!last_r || out_free);
  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r    <= in_ch.char_byte;
      present_r <= in_ch.byte_present;
      last_r    <= in_ch.is_last;
    end
  end

  assign step.valid        = adv;
  assign step.char_byte    = char_r;
  assign step.byte_present = present_r;
  assign step.is_last      = last_r;

endmodule

@@ sv/ccdp_parser.sv @@
// Directive state machine, value accumulator and policy registers.
module ccdp_parser import ccdp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ccdp_step_t   step,
  output ccdp_policy_t policy
);

  logic [2:0]          phase_r, phase_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic [NUM_KW-1:0]   alive_r, alive_nxt;
  logic                psp_r, psp_nxt;
  logic                neg_r, neg_nxt;
  logic                dseen_r, dseen_nxt;
  logic [AGE_BITS-1:0] acc_r, acc_nxt;
  logic                ovf_r, ovf_nxt;
  logic [2:0]          flags_r, flags_nxt;
  logic [AGE_BITS-1:0] ma_val_r, ma_val_nxt;
  logic                ma_ok_r, ma_ok_nxt;
  logic [AGE_BITS-1:0] sa_val_r, sa_val_nxt;
  logic                sa_ok_r, sa_ok_nxt;

  logic [7:0]          lc;
  logic                is_dig;
  logic                ws;
  logic                comma;
  logic [PROD_W-1:0]   prod;
  logic                prod_big;
  logic [2:0]          nc_phase;
  logic [3:0]          nc_pos;
  logic [NUM_KW-1:0]   nc_alive;
  logic [NUM_KW-1:0]   kw_hit;

  assign is_dig = step.char_byte >= CH_ZERO && step.char_byte <= CH_NINE;
  assign lc     = (step.char_byte >= CH_UP_A && step.char_byte <= CH_UP_Z) ?
                  (step.char_byte | 8'h20) : step.char_byte;
  assign ws     = is_ws(lc);
  assign comma  = step.byte_present && (lc == CH_COMMA);

  // acc * 10 + digit, wide enough to see any overflow
  assign prod = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1)
              + PROD_W'(step.char_byte - CH_ZERO);
  assign prod_big = |prod[PROD_W-1:AGE_BITS];

  // Next state for a byte that starts or continues a directive name
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      kw_hit[k] = (pos_r < KW_LEN[k]) && (kw_char(k, pos_r[2:0]) == lc);
    end
    nc_pos   = pos_r;
    nc_alive = alive_r;
    nc_phase = PH_NAME;
    if (psp_r) begin
      nc_phase = PH_DEAD;
    end else if (lc == CH_EQ) begin
      if (pos_r == 4'd7 && alive_r[KW_MAXAGE]) begin
        nc_alive = KW_ONLY_MAX;
        nc_phase = PH_VAL_WS;
      end else if (pos_r == 4'd8 && alive_r[KW_SMAXAGE]) begin
        nc_alive = KW_ONLY_SMX;
        nc_phase = PH_VAL_WS;
      end else begin
        nc_phase = PH_DEAD;
      end
    end else begin
      nc_alive = alive_r & kw_hit;
      if (pos_r != 4'd15) nc_pos = pos_r + 4'd1;
      if (nc_alive == '0) nc_phase = PH_DEAD;
    end
  end

  always_comb begin
    logic do_add;
    do_add     = 1'b0;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    alive_nxt  = alive_r;
    psp_nxt    = psp_r;
    neg_nxt    = neg_r;
    dseen_nxt  = dseen_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    flags_nxt  = flags_r;
    ma_val_nxt = ma_val_r;
    ma_ok_nxt  = ma_ok_r;
    sa_val_nxt = sa_val_r;
    sa_ok_nxt  = sa_ok_r;

    if (step.valid && step.byte_present && !comma) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (!ws) begin
            phase_nxt = nc_phase;
            pos_nxt   = nc_pos;
            alive_nxt = nc_alive;
          end
        end
        PH_NAME: begin
          if (ws) begin
            psp_nxt = 1'b1;
          end else begin
            phase_nxt = nc_phase;
            pos_nxt   = nc_pos;
            alive_nxt = nc_alive;
          end
        end
        PH_VAL_WS: begin
          if (!ws) begin
            if (lc == CH_PLUS || lc == CH_MINUS) begin
              neg_nxt   = (lc == CH_MINUS);
              phase_nxt = PH_VAL_SIGN;
            end else if (is_dig) begin
              phase_nxt = PH_VAL_DIGITS;
              do_add    = 1'b1;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
        end
        PH_VAL_SIGN: begin
          if (is_dig) begin
            phase_nxt = PH_VAL_DIGITS;
            do_add    = 1'b1;
          end else begin
            phase_nxt = PH_DEAD;
          end
        end
        PH_VAL_DIGITS: begin
          if (is_dig) do_add = 1'b1;
          else        phase_nxt = PH_VAL_DONE;
        end
        default: begin
        end
      endcase
    end

    if (do_add) begin
      dseen_nxt = 1'b1;
      if (!ovf_r) begin
        if (prod_big) ovf_nxt = 1'b1;
        else          acc_nxt = prod[AGE_BITS-1:0];
      end
    end

    // Close the directive on a comma or at the end of the header
    if (step.valid && (comma || step.is_last)) begin
      if (phase_nxt == PH_NAME) begin
        if (pos_nxt == 4'd8 && alive_nxt[KW_NOSTORE]) flags_nxt[0] = 1'b1;
        if (pos_nxt == 4'd8 && alive_nxt[KW_NOCACHE]) flags_nxt[1] = 1'b1;
        if (pos_nxt == 4'd7 && alive_nxt[KW_PRIVATE]) flags_nxt[2] = 1'b1;
      end else if ((phase_nxt == PH_VAL_DIGITS || phase_nxt == PH_VAL_DONE) && dseen_nxt) begin
        if (!ovf_nxt && !(neg_nxt && acc_nxt != '0)) begin
          if (alive_nxt == KW_ONLY_MAX) begin
            ma_val_nxt = acc_nxt;
            ma_ok_nxt  = 1'b1;
          end else if (alive_nxt == KW_ONLY_SMX) begin
            sa_val_nxt = acc_nxt;
            sa_ok_nxt  = 1'b1;
          end
        end
      end
    end

    policy.no_store               = flags_nxt[0];
    policy.no_cache               = flags_nxt[1];
    policy.is_private             = flags_nxt[2];
    policy.max_age                = ma_ok_nxt ? OUT_AGE_W'(ma_val_nxt) : '0;
    policy.max_age_present        = ma_ok_nxt;
    policy.shared_max_age         = sa_ok_nxt ? OUT_AGE_W'(sa_val_nxt) : '0;
    policy.shared_max_age_present = sa_ok_nxt;

    if (step.valid && (comma || step.is_last)) begin
      phase_nxt = PH_LEAD;
      pos_nxt   = '0;
      alive_nxt = KW_ALL;
      psp_nxt   = 1'b0;
      neg_nxt   = 1'b0;
      dseen_nxt = 1'b0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
    if (step.valid && step.is_last) begin
      flags_nxt  = '0;
      ma_val_nxt = '0;
      ma_ok_nxt  = 1'b0;
      sa_val_nxt = '0;
      sa_ok_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      pos_r    <= '0;
      alive_r  <= KW_ALL;
      psp_r    <= 1'b0;
      neg_r    <= 1'b0;
      dseen_r  <= 1'b0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      flags_r  <= '0;
      ma_val_r <= '0;
      ma_ok_r  <= 1'b0;
      sa_val_r <= '0;
      sa_ok_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      alive_r  <= alive_nxt;
      psp_r    <= psp_nxt;
      neg_r    <= neg_nxt;
      dseen_r  <= dseen_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      flags_r  <= flags_nxt;
      ma_val_r <= ma_val_nxt;
      ma_ok_r  <= ma_ok_nxt;
      sa_val_r <= sa_val_nxt;
      sa_ok_r  <= sa_ok_nxt;
    end
  end

  a_val_one_kw: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VAL_WS || phase_r == PH_VAL_SIGN || phase_r == PH_VAL_DIGITS ||
     phase_r == PH_VAL_DONE) |-> (alive_r == KW_ONLY_MAX || alive_r == KW_ONLY_SMX))
    else $error("value phase without a single age keyword");

  a_acc_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r != '0 || ovf_r) |-> dseen_r)
    else $error("accumulator loaded without a digit");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step.valid && step.is_last) |=>
      (phase_r == PH_LEAD && flags_r == '0 && !ma_ok_r && !sa_ok_r))
    else $error("state not cleared after end of header");

  a_age_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !ma_ok_r |-> (ma_val_r == '0))
    else $error("max-age value held without valid flag");

endmodule

@@ sv/ccdp_out_reg.sv @@
// Result register: holds one parsed policy until the sink takes it.
module ccdp_out_reg import ccdp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ccdp_step_t   step,
  input  ccdp_policy_t policy,
  output logic         out_free,
  ccdp_out_if.source   out_ch
);

  logic         valid_r, valid_nxt;
  logic         load;
  ccdp_policy_t pol_r;

  assign out_free  = !valid_r || out_ch.ready;
  assign load      = step.valid && step.is_last;
  assign valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) pol_r <= policy;
  end

  assign out_ch.valid                  = valid_r;
  assign out_ch.no_store               = pol_r.no_store;
  assign out_ch.no_cache               = pol_r.no_cache;
  assign out_ch.is_private             = pol_r.is_private;
  assign out_ch.max_age                = pol_r.max_age;
  assign out_ch.max_age_present        = pol_r.max_age_present;
  assign out_ch.shared_max_age         = pol_r.shared_max_age;
  assign out_ch.shared_max_age_present = pol_r.shared_max_age_present;

endmodule

@@ sv/cache_control_directive_parser.sv @@
// Output: a header's policy is loaded into the result register when the input register releases its last request.
// Throughput: one request per cycle; the input register stalls only on a last
//   request while the result register still holds an untaken policy.
// Reset: synchronous, active low; clears handshake state, the directive state
//   and the policy so the first header starts clean.
// Top level of the Cache-Control directive parser.
module cache_control_directive_parser import ccdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ccdp_in_if.sink    in_ch,
  ccdp_out_if.source out_ch
);

  ccdp_step_t   step;
  ccdp_policy_t policy;
  logic         out_free;

  ccdp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .step     (step)
  );

  ccdp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .policy (policy)
  );

  ccdp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .policy   (policy),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule
